/* design/url_dec_pkg.sv */
package url_dec_pkg;

	localparam int unsigned MaxBeats = 3;
	localparam int unsigned CntW     = 2;

	localparam logic [7:0] ChPct   = 8'h25;
	localparam logic [7:0] ChPlus  = 8'h2B;
	localparam logic [7:0] ChSpace = 8'h20;

	typedef enum logic [1:0] {
		PhIdle  = 2'd0,
		PhPct   = 2'd1,
		PhDigit = 2'd2
	} phase_t;

	// bytes produced by one input item, sent as count beats
	typedef struct packed {
		logic [MaxBeats-1:0][7:0] data;
		logic [CntW-1:0]          count;
		logic                     eos;
	} burst_t;

	function automatic logic is_hex(input logic [7:0] c);
		return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
		       (c >= 8'h61 && c <= 8'h66);
	endfunction

	function automatic logic [3:0] hex_value(input logic [7:0] c);
		logic [7:0] d;
		d = 8'h00;
		if (c >= 8'h30 && c <= 8'h39) begin
			d = c - 8'h30;
		end else if (c >= 8'h41 && c <= 8'h46) begin
			d = c - 8'h37;
		end else if (c >= 8'h61 && c <= 8'h66) begin
			d = c - 8'h57;
		end
		return d[3:0];
	endfunction

	function automatic logic is_safe(input logic [7:0] v);
		return (v >= 8'd48 && v <= 8'd57) || (v >= 8'd97 && v <= 8'd122) ||
		       (v >= 8'd65 && v <= 8'd90) || v == 8'h21 || v == 8'h24 ||
		       (v >= 8'h26 && v <= 8'h2f) || v == 8'h3A || v == 8'h3B ||
		       v == 8'h3D || v == 8'h3f || v == 8'h40 || v == 8'h5f;
	endfunction

endpackage

/* design/url_dec_decode.sv */
module url_dec_decode (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  fire,
	input  logic [7:0]            in_byte,
	input  logic                  end_of_stream,
	output url_dec_pkg::burst_t   burst
);

	url_dec_pkg::phase_t phase_q, phase_d;
	logic [7:0]          first_digit_q;
	logic                hex;
	logic [7:0]          decoded;

	assign hex     = url_dec_pkg::is_hex(in_byte);
	assign decoded = {url_dec_pkg::hex_value(first_digit_q), url_dec_pkg::hex_value(in_byte)};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= url_dec_pkg::PhIdle;
			first_digit_q <= 8'h00;
		end else if (fire) begin
			phase_q <= phase_d;
			if (phase_q == url_dec_pkg::PhPct && hex) begin
				first_digit_q <= in_byte;
			end
		end
	end

	// next state
	always_comb begin
		phase_d = url_dec_pkg::PhIdle;
		unique case (phase_q)
			url_dec_pkg::PhPct: begin
				if (hex) begin
					phase_d = end_of_stream ? url_dec_pkg::PhIdle : url_dec_pkg::PhDigit;
				end else if (in_byte == url_dec_pkg::ChPct && !end_of_stream) begin
					phase_d = url_dec_pkg::PhPct;
				end
			end
			url_dec_pkg::PhDigit: begin
				if (!hex && in_byte == url_dec_pkg::ChPct && !end_of_stream) begin
					phase_d = url_dec_pkg::PhPct;
				end
			end
			default: begin
				if (in_byte == url_dec_pkg::ChPct && !end_of_stream) begin
					phase_d = url_dec_pkg::PhPct;
				end
			end
		endcase
	end

	// outputs: bytes produced by this beat
	always_comb begin
		logic [url_dec_pkg::CntW-1:0] n;
		logic                         plain;
		n          = '0;
		plain      = 1'b0;
		burst.data = '0;
		unique case (phase_q)
			url_dec_pkg::PhPct: begin
				if (hex) begin
					if (end_of_stream) begin
						burst.data[n] = url_dec_pkg::ChPct;
						n             = n + 2'd1;
						burst.data[n] = in_byte;
						n             = n + 2'd1;
					end
				end else begin
					burst.data[n] = url_dec_pkg::ChPct;
					n             = n + 2'd1;
					plain         = 1'b1;
				end
			end
			url_dec_pkg::PhDigit: begin
				if (hex) begin
					if (!url_dec_pkg::is_safe(decoded)) begin
						burst.data[n] = decoded;
						n             = n + 2'd1;
					end else begin
						burst.data[n] = url_dec_pkg::ChPct;
						n             = n + 2'd1;
						burst.data[n] = first_digit_q;
						n             = n + 2'd1;
						burst.data[n] = in_byte;
						n             = n + 2'd1;
					end
				end else begin
					burst.data[n] = url_dec_pkg::ChPct;
					n             = n + 2'd1;
					burst.data[n] = first_digit_q;
					n             = n + 2'd1;
					plain         = 1'b1;
				end
			end
			default: begin
				plain = 1'b1;
			end
		endcase
		if (plain) begin
			// a '%' opens an escape, unless the stream ends here
			if (in_byte == url_dec_pkg::ChPct) begin
				if (end_of_stream) begin
					burst.data[n] = url_dec_pkg::ChPct;
					n             = n + 2'd1;
				end
			end else if (in_byte == url_dec_pkg::ChPlus) begin
				burst.data[n] = url_dec_pkg::ChSpace;
				n             = n + 2'd1;
			end else begin
				burst.data[n] = in_byte;
				n             = n + 2'd1;
			end
		end
		burst.count = n;
		burst.eos   = end_of_stream;
	end

	a_eos_returns_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && end_of_stream) |=> phase_q == url_dec_pkg::PhIdle)
		else $error("escape still pending after final byte");

	a_eos_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && end_of_stream) |-> burst.count != '0)
		else $error("final byte produced no result");

endmodule

/* design/url_dec_serializer.sv */
module url_dec_serializer (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  url_dec_pkg::burst_t burst,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [7:0]          out_byte,
	output logic                run_last,
	output logic                stream_done
);

	url_dec_pkg::burst_t          burst_s1;
	logic                         busy_q;
	logic [url_dec_pkg::CntW-1:0] idx_q;
	logic                         in_fire;
	logic                         beat_done;

	assign out_valid   = busy_q;
	assign out_byte    = burst_s1.data[idx_q];
	assign run_last    = idx_q == burst_s1.count - 2'd1;
	assign stream_done = run_last && burst_s1.eos;
	assign beat_done   = busy_q && out_ready;
	assign in_ready    = !busy_q || (out_ready && run_last);
	assign in_fire     = in_valid && in_ready;

	always_ff @(posedge clk) begin
		if (in_fire && burst.count != '0) begin
			burst_s1 <= burst;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (in_fire && burst.count != '0) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
		end else if (beat_done) begin
			if (run_last) begin
				busy_q <= 1'b0;
				idx_q  <= '0;
			end else begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> idx_q < burst_s1.count)
		else $error("beat index past burst length");

	a_drain_then_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(beat_done && run_last && !(in_valid && burst.count != '0)) |=> !busy_q)
		else $error("serializer stayed busy after last beat");

	a_no_load_midburst: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && !run_last) |-> !in_ready)
		else $error("new item taken while burst still draining");

endmodule

/* design/url_percent_decoder_unit.sv */
// URL percent decoder.
// Input channel (in_valid/in_ready): one encoded byte per beat in in_byte;
// end_of_stream marks the final byte and flushes any pending escape.
// Output channel (out_valid/out_ready): one decoded byte per beat; run_last
// flags the last beat produced by an input beat, stream_done the last beat
// of the whole stream.
// An input beat yields zero to three output beats. A '%' or a '%' plus one
// hex digit is held inside the block with no output until the escape
// completes, breaks, or the stream ends.
// Latency: the first output beat of an item is visible the cycle after the
// item is taken (decode is one level of logic into the output register).
// Throughput: one input beat per cycle while each item gives at most one
// byte and the receiver takes every beat; an item giving k bytes holds the
// output register for k beats, so in_ready drops until its last beat is
// taken. Items giving no byte load nothing into the output register. in_ready
// depends combinationally on out_ready through the last-beat check.
// Reset clears the escape state and empties the output register. When the
// receiver stalls, the current beat holds and input is held off.
module url_percent_decoder_unit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	input  logic       end_of_stream,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       run_last,
	output logic       stream_done
);

	url_dec_pkg::burst_t burst;
	logic                fire;

	assign fire = in_valid && in_ready;

	url_dec_decode u_decode (
		.clk           (clk),
		.arst_n        (arst_n),
		.fire          (fire),
		.in_byte       (in_byte),
		.end_of_stream (end_of_stream),
		.burst         (burst)
	);

	url_dec_serializer u_serializer (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.burst       (burst),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_byte    (out_byte),
		.run_last    (run_last),
		.stream_done (stream_done)
	);

endmodule

/* verif/tb_url_percent_decoder_unit.sv */
`timescale 1ns / 1ps

module tb_url_percent_decoder_unit;

	localparam int IDLE_PCT     = 19;
	localparam int RAND_ITEMS   = 225;
	localparam int STALL_LIMIT  = 1000;
	localparam int DRAIN_CYCLES = 4;
	localparam int REPORT_MAX   = 10;
	localparam int PLAN_LEN     = 25;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic       done;
	} dec_beat_t;

	// one directed beat; typed rows carry their decoded bytes, the rest go to the decoder
	typedef struct packed {
		logic [7:0] b;
		logic       fin;
		logic       typed;
		logic [1:0] n;
		logic [7:0] x0;
		logic [7:0] x1;
		logic [7:0] x2;
	} plan_row_t;

	logic       clk           = 1'b0;
	logic       arst_n        = 1'b0;
	logic       in_valid      = 1'b0;
	logic       in_ready;
	logic [7:0] in_byte       = 8'h00;
	logic       end_of_stream = 1'b0;
	logic       out_valid;
	logic       out_ready     = 1'b0;
	logic [7:0] out_byte;
	logic       run_last;
	logic       stream_done;

	bit         calm = 1'b0;
	int         errors = 0;
	int         stall_cycles = 0;
	dec_beat_t  decoded_q[$];
	dec_beat_t  want;

	// decoder state
	url_dec_pkg::phase_t esc_ph = url_dec_pkg::PhIdle;
	logic [7:0] held_digit = 8'h00;
	logic [7:0] burst_bytes[$];

	plan_row_t plan [PLAN_LEN] = '{
		'{8'h61, 1'b0, 1'b1, 2'd1, 8'h61, 8'h00, 8'h00},
		'{8'h00, 1'b0, 1'b1, 2'd1, 8'h00, 8'h00, 8'h00},
		'{8'hFF, 1'b0, 1'b1, 2'd1, 8'hFF, 8'h00, 8'h00},
		'{url_dec_pkg::ChPlus, 1'b0, 1'b1, 2'd1, url_dec_pkg::ChSpace, 8'h00, 8'h00},
		// %20 decodes to a space, outside the safe set
		'{url_dec_pkg::ChPct, 1'b0, 1'b1, 2'd0, 8'h00, 8'h00, 8'h00},
		'{8'h32, 1'b0, 1'b1, 2'd0, 8'h00, 8'h00, 8'h00},
		'{8'h30, 1'b0, 1'b1, 2'd1, url_dec_pkg::ChSpace, 8'h00, 8'h00},
		// %41 is 'A', safe, so all three bytes pass literally
		'{url_dec_pkg::ChPct, 1'b0, 1'b1, 2'd0, 8'h00, 8'h00, 8'h00},
		'{8'h34, 1'b0, 1'b1, 2'd0, 8'h00, 8'h00, 8'h00},
		'{8'h31, 1'b0, 1'b1, 2'd3, url_dec_pkg::ChPct, 8'h34, 8'h31},
		// broken escape after the percent
		'{url_dec_pkg::ChPct, 1'b0, 1'b1, 2'd0, 8'h00, 8'h00, 8'h00},
		'{8'h47, 1'b0, 1'b1, 2'd2, url_dec_pkg::ChPct, 8'h47, 8'h00},
		// plus breaks escape after first digit
		'{url_dec_pkg::ChPct, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00},
		'{8'h61, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00},
		'{url_dec_pkg::ChPlus, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00},
		// a second percent reopens the escape
		'{url_dec_pkg::ChPct, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00},
		'{url_dec_pkg::ChPct, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00},
		'{8'h66, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00},
		'{8'h66, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00},
		'{url_dec_pkg::ChPct, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00},
		'{8'h46, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00},
		'{8'h65, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00},
		// end of stream flushes a pending percent / percent plus digit
		'{url_dec_pkg::ChPct, 1'b1, 1'b1, 2'd1, url_dec_pkg::ChPct, 8'h00, 8'h00},
		'{url_dec_pkg::ChPct, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00},
		'{8'h33, 1'b1, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00}
	};

	url_percent_decoder_unit u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.in_byte      (in_byte),
		.end_of_stream(end_of_stream),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_byte     (out_byte),
		.run_last     (run_last),
		.stream_done  (stream_done)
	);

	always #1 clk = ~clk;

	function automatic bit is_hex_char(input logic [7:0] c);
		return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
		       (c >= 8'h61 && c <= 8'h66);
	endfunction

	function automatic logic [3:0] nibble_of(input logic [7:0] c);
		logic [7:0] v;
		v = 8'h00;
		if (c >= 8'h30 && c <= 8'h39) begin
			v = c - 8'h30;
		end else if (c >= 8'h41 && c <= 8'h46) begin
			v = c - 8'h41 + 8'd10;
		end else if (c >= 8'h61 && c <= 8'h66) begin
			v = c - 8'h61 + 8'd10;
		end
		return v[3:0];
	endfunction

	// bytes that must stay escaped-literal rather than decode
	function automatic bit url_safe(input logic [7:0] v);
		return (v >= 8'h30 && v <= 8'h39) || (v >= 8'h41 && v <= 8'h5a) ||
		       (v >= 8'h61 && v <= 8'h7a) || v == 8'h21 || v == 8'h24 ||
		       (v >= 8'h26 && v <= 8'h2f) || v == 8'h3a || v == 8'h3b ||
		       v == 8'h3d || v == 8'h3f || v == 8'h40 || v == 8'h5f;
	endfunction

	function automatic logic [7:0] hex_char();
		int n;
		n = $urandom_range(21);
		if (n < 10) begin
			return 8'h30 + n[7:0];
		end else if (n < 16) begin
			return 8'h41 + n[7:0] - 8'd10;
		end
		return 8'h61 + n[7:0] - 8'd16;
	endfunction

	task automatic take_plain(input logic [7:0] b);
		if (b == url_dec_pkg::ChPct) begin
			esc_ph = url_dec_pkg::PhPct;
		end else if (b == url_dec_pkg::ChPlus) begin
			burst_bytes.push_back(url_dec_pkg::ChSpace);
		end else begin
			burst_bytes.push_back(b);
		end
	endtask

	// runs one input byte through the decoder, leaving its output in burst_bytes
	task automatic advance_decoder(input logic [7:0] b, input logic fin);
		logic [7:0] val;
		burst_bytes = {};
		case (esc_ph)
			url_dec_pkg::PhPct: begin
				if (is_hex_char(b)) begin
					held_digit = b;
					esc_ph = url_dec_pkg::PhDigit;
				end else begin
					burst_bytes.push_back(url_dec_pkg::ChPct);
					esc_ph = url_dec_pkg::PhIdle;
					take_plain(b);
				end
			end
			url_dec_pkg::PhDigit: begin
				if (is_hex_char(b)) begin
					val = {nibble_of(held_digit), nibble_of(b)};
					esc_ph = url_dec_pkg::PhIdle;
					if (url_safe(val)) begin
						burst_bytes.push_back(url_dec_pkg::ChPct);
						burst_bytes.push_back(held_digit);
						burst_bytes.push_back(b);
					end else begin
						burst_bytes.push_back(val);
					end
				end else begin
					burst_bytes.push_back(url_dec_pkg::ChPct);
					burst_bytes.push_back(held_digit);
					esc_ph = url_dec_pkg::PhIdle;
					take_plain(b);
				end
			end
			default: begin
				esc_ph = url_dec_pkg::PhIdle;
				take_plain(b);
			end
		endcase
		if (fin) begin
			if (esc_ph == url_dec_pkg::PhPct) begin
				burst_bytes.push_back(url_dec_pkg::ChPct);
			end else if (esc_ph == url_dec_pkg::PhDigit) begin
				burst_bytes.push_back(url_dec_pkg::ChPct);
				burst_bytes.push_back(held_digit);
			end
			esc_ph = url_dec_pkg::PhIdle;
		end
	endtask

	task automatic queue_burst(input logic fin);
		dec_beat_t beat;
		for (int k = 0; k < burst_bytes.size(); k++) begin
			beat.data = burst_bytes[k];
			beat.last = (k == burst_bytes.size() - 1);
			beat.done = beat.last && fin;
			decoded_q.push_back(beat);
		end
	endtask

	task automatic drive_beat(input logic [7:0] b, input logic fin);
		@(negedge clk);
		while (!calm && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid      <= 1'b1;
		in_byte       <= b;
		end_of_stream <= fin;
		@(posedge clk);
		while (!in_ready) begin
			@(posedge clk);
		end
	endtask

	always @(negedge clk) begin
		out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (decoded_q.size() == 0) begin
				errors = errors + 1;
				if (errors <= REPORT_MAX) begin
					$display("unexpected beat: byte %h last %b done %b",
					         out_byte, run_last, stream_done);
				end
			end else begin
				want = decoded_q.pop_front();
				if (out_byte !== want.data || run_last !== want.last ||
				    stream_done !== want.done) begin
					errors = errors + 1;
					if (errors <= REPORT_MAX) begin
						$display("mismatch: exp byte %h last %b done %b, got %h %b %b",
						         want.data, want.last, want.done,
						         out_byte, run_last, stream_done);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("url_percent_decoder_unit verification failed");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	initial begin
		int         sent;
		int         kind;
		logic [7:0] pick;
		logic       fin;
		logic [7:0] seq[$];

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (plan[i]) begin
			drive_beat(plan[i].b, plan[i].fin);
			advance_decoder(plan[i].b, plan[i].fin);
			if (plan[i].typed) begin
				burst_bytes = {};
				if (plan[i].n > 0) burst_bytes.push_back(plan[i].x0);
				if (plan[i].n > 1) burst_bytes.push_back(plan[i].x1);
				if (plan[i].n > 2) burst_bytes.push_back(plan[i].x2);
			end
			queue_burst(plan[i].fin);
		end

		sent = 0;
		while (sent < RAND_ITEMS) begin
			kind = $urandom_range(99);
			seq = {};
			if (kind < 15) begin
				pick = 8'($urandom_range(255));
				seq.push_back(pick);
			end else if (kind < 25) begin
				seq.push_back(url_dec_pkg::ChPlus);
			end else if (kind < 60) begin
				seq.push_back(url_dec_pkg::ChPct);
				seq.push_back(hex_char());
				seq.push_back(hex_char());
			end else if (kind < 75) begin
				// escape followed by an arbitrary byte, which may complete it or cut it short
				seq.push_back(url_dec_pkg::ChPct);
				if ($urandom_range(1)) seq.push_back(hex_char());
				pick = 8'($urandom_range(255));
				seq.push_back(pick);
			end else if (kind < 85) begin
				seq.push_back(url_dec_pkg::ChPct);
				seq.push_back(url_dec_pkg::ChPct);
			end else begin
				pick = 8'($urandom_range(8'h7e, 8'h20));
				seq.push_back(pick);
			end
			foreach (seq[k]) begin
				calm = (sent >= 120 && sent < 180);
				fin = ($urandom_range(24) == 0);
				drive_beat(seq[k], fin);
				advance_decoder(seq[k], fin);
				queue_burst(fin);
				sent = sent + 1;
			end
		end

		@(negedge clk);
		in_valid <= 1'b0;
		calm = 1'b0;
		while (decoded_q.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0) begin
			$display("url_percent_decoder_unit verification clean");
		end else begin
			$display("url_percent_decoder_unit verification failed");
		end
		$finish;
	end

endmodule
